// ===== sv/lzwc_pkg.sv =====
// Shared types, constants and helpers for the LZW variable-width compressor.
package lzwc_pkg;

   localparam int MaxDictCode = 4095;
   localparam int DictCodeW   = $clog2(MaxDictCode + 1);
   localparam int NextCodeW   = DictCodeW + 1;
   localparam int HashW       = DictCodeW + 1;
   localparam int HashDepth   = 1 << HashW;
   localparam int AccW        = 23;
   localparam int CntW        = 5;
   localparam int WidthW      = 5;
   localparam int ThrW        = 17;

   localparam logic [NextCodeW-1:0] FirstFree   = NextCodeW'(257);
   localparam logic [DictCodeW-1:0] EndCode     = DictCodeW'(256);
   localparam logic [WidthW-1:0]    StartWidth  = WidthW'(9);
   localparam logic [ThrW-1:0]      StartThresh = ThrW'(512);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE,
      ST_CHECK,
      ST_DRAIN_DATA,
      ST_DRAIN_PFX,
      ST_DRAIN_END,
      ST_FINAL
   } state_type;

   // One hash-table slot: the pair (prefix, byte) and the code it names.
   typedef struct packed {
      logic                 valid;
      logic [DictCodeW-1:0] prefix;
      logic [7:0]           byte_val;
      logic [DictCodeW-1:0] code;
   } entry_type;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic set_prefix;
      logic take_hit;
      logic probe_next;
      logic miss;
      logic pack_prefix;
      logic pack_end;
      logic drain;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic prefix_valid;
      logic hit;
      logic occupied;
      logic bits_ge8;
      logic out_free;
   } status_type;

   // Fold the 20-bit pair into a table index.
   function automatic logic [HashW-1:0] hash_pair(input logic [DictCodeW-1:0] pfx,
                                                  input logic [7:0] b);
      hash_pair = HashW'(pfx) ^ HashW'({b, 5'b0}) ^ HashW'(b);
   endfunction

endpackage

// ===== sv/lzwc_ctrl.sv =====
// Controller state machine: sequences clearing, lookup, packing and drain.
module lzwc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_op,
   output logic                   req_stall,
   input  lzwc_pkg::status_type   status,
   output lzwc_pkg::cmd_type      cmd
);

   lzwc_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= lzwc_pkg::ST_CLEAR;
      else       state_ff <= state_in;
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != lzwc_pkg::ST_IDLE);
      unique case (state_ff)
         lzwc_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) state_in = lzwc_pkg::ST_IDLE;
         end
         lzwc_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (!req_op) begin
                  if (!status.prefix_valid) cmd.set_prefix = 1'b1;
                  else                      state_in = lzwc_pkg::ST_PROBE;
               end else if (status.prefix_valid) begin
                  cmd.pack_prefix = 1'b1;
                  state_in        = lzwc_pkg::ST_DRAIN_PFX;
               end else begin
                  cmd.pack_end = 1'b1;
                  state_in     = lzwc_pkg::ST_DRAIN_END;
               end
            end
         end
         lzwc_pkg::ST_PROBE: begin
            state_in = lzwc_pkg::ST_CHECK;
         end
         lzwc_pkg::ST_CHECK: begin
            if (status.hit) begin
               cmd.take_hit = 1'b1;
               state_in     = lzwc_pkg::ST_IDLE;
            end else if (status.occupied) begin
               cmd.probe_next = 1'b1;
               state_in       = lzwc_pkg::ST_PROBE;
            end else begin
               cmd.miss        = 1'b1;
               cmd.pack_prefix = 1'b1;
               state_in        = lzwc_pkg::ST_DRAIN_DATA;
            end
         end
         lzwc_pkg::ST_DRAIN_DATA: begin
            if (!status.bits_ge8)      state_in  = lzwc_pkg::ST_IDLE;
            else if (status.out_free)  cmd.drain = 1'b1;
         end
         lzwc_pkg::ST_DRAIN_PFX: begin
            if (!status.bits_ge8) begin
               cmd.pack_end = 1'b1;
               state_in     = lzwc_pkg::ST_DRAIN_END;
            end else if (status.out_free) begin
               cmd.drain = 1'b1;
            end
         end
         lzwc_pkg::ST_DRAIN_END: begin
            if (!status.bits_ge8)      state_in  = lzwc_pkg::ST_FINAL;
            else if (status.out_free)  cmd.drain = 1'b1;
         end
         lzwc_pkg::ST_FINAL: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = lzwc_pkg::ST_CLEAR;
            end
         end
         default: state_in = lzwc_pkg::ST_CLEAR;
      endcase
   end

endmodule

// ===== sv/lzwc_datapath.sv =====
// Datapath: hash-table dictionary, prefix and code counters, bit packer, output register.
module lzwc_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_data_byte,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_last,
   input  lzwc_pkg::cmd_type      cmd,
   output lzwc_pkg::status_type   status
);

   lzwc_pkg::entry_type mem [lzwc_pkg::HashDepth];
   lzwc_pkg::entry_type rd_ff;

   logic [lzwc_pkg::HashW-1:0]     clr_ff, addr_ff, addr_in;
   logic [lzwc_pkg::DictCodeW-1:0] prefix_ff, prefix_in;
   logic                           pv_ff, pv_in;
   logic [7:0]                     byte_ff;
   logic [lzwc_pkg::NextCodeW-1:0] nf_ff, nf_in;
   logic [lzwc_pkg::WidthW-1:0]    width_ff, width_in;
   logic [lzwc_pkg::ThrW-1:0]      thr_ff, thr_in;
   logic [lzwc_pkg::AccW-1:0]      acc_ff, acc_in;
   logic [lzwc_pkg::CntW-1:0]      cnt_ff, cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [7:0]                     rsp_byte_ff;
   logic                           rsp_last_ff;

   logic                           room, do_insert, pack, out_free;
   logic [lzwc_pkg::DictCodeW-1:0] pack_code, code_mask;
   lzwc_pkg::entry_type            wr_entry;

   assign room      = (nf_ff <= lzwc_pkg::NextCodeW'(lzwc_pkg::MaxDictCode));
   assign do_insert = cmd.miss && room;
   assign pack      = cmd.pack_prefix || cmd.pack_end;
   assign pack_code = cmd.pack_end ? lzwc_pkg::EndCode : prefix_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign wr_entry.valid    = 1'b1;
   assign wr_entry.prefix   = prefix_ff;
   assign wr_entry.byte_val = byte_ff;
   assign wr_entry.code     = nf_ff[lzwc_pkg::DictCodeW-1:0];

   // Dictionary memory: one write port, registered read at the probe address
   always_ff @(posedge clock) begin
      if (cmd.clear_step)  mem[clr_ff]  <= '0;
      else if (do_insert)  mem[addr_ff] <= wr_entry;
      rd_ff <= mem[addr_ff];
   end

   // Code mask for the current width
   always_comb begin
      for (int i = 0; i < lzwc_pkg::DictCodeW; i++) begin
         code_mask[i] = (lzwc_pkg::WidthW'(i) < width_ff);
      end
   end

   // Next values of prefix, counters and packer
   always_comb begin
      addr_in  = addr_ff;
      prefix_in = prefix_ff;
      pv_in    = pv_ff;
      nf_in    = nf_ff;
      width_in = width_ff;
      thr_in   = thr_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;

      if (cmd.accept) addr_in = lzwc_pkg::hash_pair(prefix_ff, req_data_byte);
      if (cmd.probe_next) addr_in = addr_ff + 1'b1;
      if (cmd.set_prefix) begin
         prefix_in = lzwc_pkg::DictCodeW'(req_data_byte);
         pv_in     = 1'b1;
      end
      if (cmd.take_hit) prefix_in = rd_ff.code;
      if (cmd.miss) prefix_in = lzwc_pkg::DictCodeW'(byte_ff);
      if (do_insert) nf_in = nf_ff + 1'b1;

      // Pack one code at the current width, then widen on threshold
      if (pack) begin
         acc_in = acc_ff | lzwc_pkg::AccW'(lzwc_pkg::AccW'(pack_code & code_mask) << cnt_ff);
         cnt_in = cnt_ff + lzwc_pkg::CntW'(width_ff);
         if (lzwc_pkg::ThrW'(nf_in - 1'b1) == thr_in &&
             (nf_in - 1'b1) == lzwc_pkg::NextCodeW'(thr_ff)) begin
            thr_in   = lzwc_pkg::ThrW'({thr_ff, 1'b0});
            width_in = width_ff + 1'b1;
         end
      end
      if (cmd.drain) begin
         acc_in = acc_ff >> 8;
         cnt_in = cnt_ff - lzwc_pkg::CntW'(8);
      end
   end

   // Output register next valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.drain || cmd.finish) rsp_valid_in = 1'b1;
      else if (!rsp_stall)         rsp_valid_in = 1'b0;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         clr_ff   <= '0;
         pv_ff    <= 1'b0;
         nf_ff    <= lzwc_pkg::FirstFree;
         width_ff <= lzwc_pkg::StartWidth;
         thr_ff   <= lzwc_pkg::StartThresh;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         prefix_ff <= '0;
      end else begin
         if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
         pv_ff    <= pv_in;
         nf_ff    <= nf_in;
         width_ff <= width_in;
         thr_ff   <= thr_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         prefix_ff <= prefix_in;
      end
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   // Payload registers
   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      if (cmd.accept) byte_ff <= req_data_byte;
      if (cmd.drain || cmd.finish) begin
         rsp_byte_ff <= acc_ff[7:0];
         rsp_last_ff <= cmd.finish;
      end
   end

   assign status.clear_done   = (clr_ff == '1);
   assign status.prefix_valid = pv_ff;
   assign status.occupied     = rd_ff.valid;
   assign status.hit          = rd_ff.valid && rd_ff.prefix == prefix_ff &&
                                rd_ff.byte_val == byte_ff;
   assign status.bits_ge8     = (cnt_ff >= lzwc_pkg::CntW'(8));
   assign status.out_free     = out_free;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// ===== sv/lzw_variable_width_compressor_core.sv =====
// LZW compressor core with variable code width: top level joining controller and datapath.
// The dictionary is an 8192-slot hash table in one memory with linear probing. After
// reset and after every end of stream the table is swept clear, one slot per cycle,
// with the input stalled. A data byte that only starts a prefix is taken in idle;
// otherwise each probe of the table memory passes through the probe and check states,
// and a byte that misses then drains each packed output byte before returning to idle.
// End of stream packs the pending prefix if any, then the end code, drains each packed
// output byte, sends the final byte and starts the clearing sweep. Output stalls can hold each drain.
module lzw_variable_width_compressor_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_op,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);

   lzwc_pkg::cmd_type    cmd;
   lzwc_pkg::status_type status;

   lzwc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lzwc_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_data_byte (req_data_byte),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last      (rsp_last),
      .cmd           (cmd),
      .status        (status)
   );

endmodule

// ===== sv/lzwc_checker.sv =====
// Port-level checker for the compressor core and its bind.
module lzwc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_op,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last
);

   // Clearing sweep follows reset: no transaction taken
   assert property (@(posedge clock) $past(reset) |-> req_stall)
      else $error("input taken right after reset");

   // End of stream always keeps the input stalled while it packs
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_op |=> req_stall)
      else $error("input taken during end of stream");

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("stalled result changed");

endmodule

bind lzw_variable_width_compressor_core lzwc_checker u_lzwc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_op       (req_op),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte),
   .rsp_last     (rsp_last)
);

// ===== verif/lzw_variable_width_compressor_core_test.sv =====
// Self-checking testbench for the LZW variable-width compressor core.
module lzw_variable_width_compressor_core_test;

   typedef struct {
      logic [7:0] out_byte;
      logic       last;
   } out_item_type;

   // Tracks LZW state, predicts the packed byte stream and checks it
   class lzw_scoreboard;
      int unsigned   pair_code[bit [19:0]];
      int unsigned   prefix_code;
      bit            prefix_valid;
      int unsigned   free_code;
      int unsigned   code_width;
      int unsigned   threshold;
      int unsigned   acc;
      int unsigned   bit_count;
      int            step_bytes;
      out_item_type  expected_bytes[$];
      int            mismatches;

      function new();
         mismatches = 0;
         clear_state();
      endfunction

      function void clear_state();
         pair_code.delete();
         prefix_code  = 0;
         prefix_valid = 0;
         free_code    = 257;
         code_width   = 9;
         threshold    = 512;
         acc          = 0;
         bit_count    = 0;
      endfunction

      function void push_byte(int unsigned b, bit last);
         out_item_type e;
         e.out_byte = b[7:0];
         e.last     = last;
         expected_bytes.push_back(e);
         step_bytes++;
      endfunction

      // Pack one code LSB-first and drain whole bytes
      function void pack_code(int unsigned code);
         int unsigned w;
         int unsigned mask;
         w = code_width & 31;
         mask = (1 << w) - 1;
         if (bit_count < 24) acc |= (code & mask) << bit_count;
         acc &= 32'h7FFFFF;
         bit_count += w;
         if (free_code - 1 == threshold) begin
            threshold  = (threshold * 2) & 32'h1FFFF;
            code_width = (code_width + 1) & 31;
         end
         while (bit_count >= 8 && step_bytes < 5) begin
            push_byte(acc, 0);
            acc >>= 8;
            bit_count -= 8;
         end
      endfunction

      function void note_input(bit op, logic [7:0] b);
         bit [19:0] key;
         step_bytes = 0;
         if (!op) begin
            if (!prefix_valid) begin
               prefix_code  = b;
               prefix_valid = 1;
               return;
            end
            key = {prefix_code[11:0], b};
            if (pair_code.exists(key)) begin
               prefix_code = pair_code[key];
               return;
            end
            if (free_code <= lzwc_pkg::MaxDictCode) begin
               pair_code[key] = free_code;
               free_code++;
            end
            pack_code(prefix_code);
            prefix_code = b;
            return;
         end
         if (prefix_valid) pack_code(prefix_code);
         pack_code(256);
         push_byte(acc, 1);
         clear_state();
      endfunction

      function void check(logic [7:0] out_byte, logic last);
         out_item_type e;
         if (expected_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected output byte %02h last %0b", out_byte, last);
            return;
         end
         e = expected_bytes.pop_front();
         if (out_byte !== e.out_byte || last !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                        e.out_byte, e.last, out_byte, last);
         end
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction
   endclass

   localparam int StallLimit = 40000;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_stall;
   logic       req_op = 0;
   logic [7:0] req_data_byte = 0;
   logic       rsp_valid;
   logic       rsp_stall = 0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;

   lzw_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;

   lzw_variable_width_compressor_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_op(req_op), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte), .rsp_last(rsp_last)
   );

   always #5 clock = ~clock;

   // Randomly stall the output channel
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Check each output transaction and watch for a hang
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check(rsp_out_byte, rsp_last);
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else if (quiet_cycles >= StallLimit) begin
         $display("Regression FAIL");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // Drive one input transaction, idling first at random
   task automatic send(bit op, logic [7:0] b);
      bit stalled;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid     <= 1;
      req_op        <= op;
      req_data_byte <= b;
      // Sample stall mid-cycle so the accepting edge is seen, not the state after it
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      sb.note_input(op, b);
   endtask

   task automatic go_idle();
      req_valid <= 0;
      @(posedge clock);
   endtask

   // One stream: len bytes from an alphabet of alpha symbols (0 means full range)
   task automatic send_stream(int len, int alpha, logic [7:0] base);
      for (int i = 0; i < len; i++)
         send(0, (alpha == 0) ? 8'($urandom) : 8'(base + $urandom_range(alpha - 1)));
      send(1, 8'($urandom));
   endtask

   task automatic drain_all();
      go_idle();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int sent;
      int len;
      repeat (10) @(posedge clock);
      reset <= 0;

      // Directed: empty stream, single bytes, extremes, repeated runs
      send(1, 8'hFF);
      send(0, 8'h00); send(1, 8'h00);
      send(0, 8'hFF); send(1, 8'hA5);
      send(0, 8'h00); send(0, 8'hFF); send(0, 8'h00); send(0, 8'hFF); send(1, 8'h00);
      for (int i = 0; i < 10; i++) send(0, 8'h61);
      send(1, 8'h5A);
      // Long stream crosses the first width step
      send_stream(280, 0, 0);

      // Random phases: none, sender idle, receiver stall, both light
      for (int phase = 0; phase < 4; phase++) begin
         drain_all();
         send_idle_pct  = (phase == 1) ? 84 : (phase == 3) ? 6 : 0;
         recv_stall_pct = (phase == 2) ? 84 : (phase == 3) ? 6 : 0;
         sent = 0;
         while (sent < 35) begin
            len = $urandom_range(40);
            case ($urandom_range(3))
               0: send_stream(len, 0, 0);
               1: send_stream(len, 2, 8'($urandom));
               default: send_stream(len, 4, 8'($urandom));
            endcase
            sent += len + 1;
         end
      end

      drain_all();
      repeat (50) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
